>>> rtl/fpno_pkg.sv
// Shared constants and types of the fermion normal-ordering pipeline.
`default_nettype none

package fpno_pkg;

    localparam int MAX_PER_LIST = 4;
    localparam int INDEX_BITS   = 8;
    localparam int MERGED_MAX   = 2 * MAX_PER_LIST;

    localparam int IN_CNT_W = 3;
    localparam int LIST_W   = MAX_PER_LIST * INDEX_BITS;
    localparam int CNT_W    = $clog2(MAX_PER_LIST + 1);
    localparam int TOTAL_W  = $clog2(MERGED_MAX + 1);
    localparam int KEY_W    = INDEX_BITS + 1;
    localparam int PACK_W   = MERGED_MAX * INDEX_BITS;
    localparam int PHASE_W  = 2;

    // Odd-even transposition sort: one layer per merged entry, four per stage.
    localparam int LAYERS_PER_STAGE = 4;
    localparam int SORT_STAGES = (MERGED_MAX + LAYERS_PER_STAGE - 1) / LAYERS_PER_STAGE;

    localparam int IN_FIELDS_W  = 4 * LIST_W + 4 * IN_CNT_W;
    localparam int OUT_FIELDS_W = 2 * PACK_W + 2 * TOTAL_W + PHASE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [PHASE_W-1:0] PHASE_PLUS  = 2'b01;
    localparam logic [PHASE_W-1:0] PHASE_MINUS = 2'b11;
    localparam logic [PHASE_W-1:0] PHASE_ZERO  = 2'b00;

    // Sort key: the top bit marks an empty slot, which sorts after every index.
    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        key_t [MERGED_MAX-1:0]  keys;
        logic                   parity;
        logic [TOTAL_W-1:0]     total;
    } list_t;

    typedef struct packed {
        list_t cre;
        list_t ann;
        logic  swap_par;
    } work_t;

    // Input word, last field in the high bits so the first lands at bit 0.
    typedef struct packed {
        logic [IN_CNT_W-1:0] right_annihilator_count;
        logic [LIST_W-1:0]   right_annihilators;
        logic [IN_CNT_W-1:0] right_creator_count;
        logic [LIST_W-1:0]   right_creators;
        logic [IN_CNT_W-1:0] left_annihilator_count;
        logic [LIST_W-1:0]   left_annihilators;
        logic [IN_CNT_W-1:0] left_creator_count;
        logic [LIST_W-1:0]   left_creators;
    } op_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [TOTAL_W-1:0] annihilator_total;
        logic [PACK_W-1:0]  sorted_annihilators;
        logic [TOTAL_W-1:0] creator_total;
        logic [PACK_W-1:0]  sorted_creators;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/fpno_unpack.sv
// Input stage: clamps counts, builds the padded merged key lists and the fixed sign term.
`default_nettype none

module fpno_unpack (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire fpno_pkg::op_t   in_op,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output fpno_pkg::work_t      out_work
);

    function automatic logic [fpno_pkg::CNT_W-1:0] clamp_count(
        input logic [fpno_pkg::IN_CNT_W-1:0] c
    );
        return (c > fpno_pkg::IN_CNT_W'(fpno_pkg::MAX_PER_LIST)) ?
               fpno_pkg::CNT_W'(fpno_pkg::MAX_PER_LIST) : fpno_pkg::CNT_W'(c);
    endfunction

    // Left slots sit at 0..MAX-1 and right slots at MAX..2*MAX-1. An empty slot
    // gets a key above every index, increasing with its slot number.
    function automatic fpno_pkg::list_t merge_list(
        input logic [fpno_pkg::LIST_W-1:0] lw,
        input logic [fpno_pkg::CNT_W-1:0]  ln,
        input logic [fpno_pkg::LIST_W-1:0] rw,
        input logic [fpno_pkg::CNT_W-1:0]  rn
    );
        fpno_pkg::list_t l;
        l.parity = 1'b0;
        l.total  = fpno_pkg::TOTAL_W'(ln) + fpno_pkg::TOTAL_W'(rn);
        for (int s = 0; s < fpno_pkg::MAX_PER_LIST; s++) begin
            if (fpno_pkg::CNT_W'(s) < ln) begin
                l.keys[s] = {1'b0, lw[s*fpno_pkg::INDEX_BITS +: fpno_pkg::INDEX_BITS]};
            end else begin
                l.keys[s] = {1'b1, fpno_pkg::INDEX_BITS'(s)};
            end
            if (fpno_pkg::CNT_W'(s) < rn) begin
                l.keys[fpno_pkg::MAX_PER_LIST + s] =
                    {1'b0, rw[s*fpno_pkg::INDEX_BITS +: fpno_pkg::INDEX_BITS]};
            end else begin
                l.keys[fpno_pkg::MAX_PER_LIST + s] =
                    {1'b1, fpno_pkg::INDEX_BITS'(fpno_pkg::MAX_PER_LIST + s)};
            end
        end
        return l;
    endfunction

    logic [fpno_pkg::CNT_W-1:0] ncl, nal, ncr, nar;
    logic [fpno_pkg::CNT_W-1:0] pad_lc, pad_la;
    fpno_pkg::work_t work_next;
    fpno_pkg::work_t work_reg;
    logic            valid_reg;

    always_comb begin
        ncl    = clamp_count(in_op.left_creator_count);
        nal    = clamp_count(in_op.left_annihilator_count);
        ncr    = clamp_count(in_op.right_creator_count);
        nar    = clamp_count(in_op.right_annihilator_count);
        pad_lc = fpno_pkg::CNT_W'(fpno_pkg::MAX_PER_LIST) - ncl;
        pad_la = fpno_pkg::CNT_W'(fpno_pkg::MAX_PER_LIST) - nal;

        work_next.cre = merge_list(in_op.left_creators, ncl, in_op.right_creators, ncr);
        work_next.ann = merge_list(in_op.left_annihilators, nal,
                                   in_op.right_annihilators, nar);
        // Moving right creators past left annihilators, plus the inversions that
        // the empty left slots add ahead of the right entries in each list.
        work_next.swap_par = (nal[0] & ncr[0]) ^ (pad_lc[0] & ncr[0]) ^ (pad_la[0] & nar[0]);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fpno_sort_stage.sv
// One pipeline stage of the odd-even transposition sort, counting swaps for the sign.
`default_nettype none

module fpno_sort_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire fpno_pkg::work_t  in_work,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output fpno_pkg::work_t       out_work
);

    // Each swap is one transposition, so the swap count parity is the
    // permutation parity. Equal keys never swap.
    function automatic fpno_pkg::list_t sort_layers(input fpno_pkg::list_t l);
        fpno_pkg::list_t r;
        fpno_pkg::key_t  t;
        r = l;
        for (int layer = 0; layer < fpno_pkg::LAYERS_PER_STAGE; layer++) begin
            for (int i = 0; i < fpno_pkg::MERGED_MAX - 1; i++) begin
                if ((i % 2) == (layer % 2)) begin
                    if (r.keys[i] > r.keys[i+1]) begin
                        t            = r.keys[i];
                        r.keys[i]    = r.keys[i+1];
                        r.keys[i+1]  = t;
                        r.parity     = ~r.parity;
                    end
                end
            end
        end
        return r;
    endfunction

    fpno_pkg::work_t work_next;
    fpno_pkg::work_t work_reg;
    logic            valid_reg;

    always_comb begin
        work_next          = in_work;
        work_next.cre      = sort_layers(in_work.cre);
        work_next.ann      = sort_layers(in_work.ann);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fpno_finish.sv
// Output stage: repeat detection, packing of the sorted lists and the phase code.
`default_nettype none

module fpno_finish (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire fpno_pkg::work_t  in_work,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output fpno_pkg::result_t     out_result
);

    // Empty-slot keys are distinct and never equal an index key, so any equal
    // neighbor pair is a repeated index.
    function automatic logic has_repeat(input fpno_pkg::list_t l);
        logic rep;
        rep = 1'b0;
        for (int i = 0; i < fpno_pkg::MERGED_MAX - 1; i++) begin
            rep = rep | (l.keys[i] == l.keys[i+1]);
        end
        return rep;
    endfunction

    function automatic logic [fpno_pkg::PACK_W-1:0] pack_list(input fpno_pkg::list_t l);
        logic [fpno_pkg::PACK_W-1:0] w;
        w = '0;
        for (int i = 0; i < fpno_pkg::MERGED_MAX; i++) begin
            if (!l.keys[i][fpno_pkg::KEY_W-1]) begin
                w[i*fpno_pkg::INDEX_BITS +: fpno_pkg::INDEX_BITS] =
                    l.keys[i][fpno_pkg::INDEX_BITS-1:0];
            end
        end
        return w;
    endfunction

    fpno_pkg::result_t result_next;
    fpno_pkg::result_t result_reg;
    logic              valid_reg;
    logic              rep;
    logic              odd;

    always_comb begin
        rep = has_repeat(in_work.cre) | has_repeat(in_work.ann);
        odd = in_work.cre.parity ^ in_work.ann.parity ^ in_work.swap_par;
        result_next.sorted_creators     = pack_list(in_work.cre);
        result_next.creator_total       = in_work.cre.total;
        result_next.sorted_annihilators = pack_list(in_work.ann);
        result_next.annihilator_total   = in_work.ann.total;
        if (rep) begin
            result_next.phase = fpno_pkg::PHASE_ZERO;
        end else if (odd) begin
            result_next.phase = fpno_pkg::PHASE_MINUS;
        end else begin
            result_next.phase = fpno_pkg::PHASE_PLUS;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fermion_product_normal_order_top.sv
// Top level of the fermion operator product normal-ordering pipeline.
//
// Usage: each word on the s_ channel carries two operators, each given as
// up to four creation and up to four annihilation orbital indices with their
// counts. Counts above four are treated as four, and slots at or above a
// count are ignored. For every accepted word exactly one word leaves on the
// m_ channel: the merged creators (left then right) and merged annihilators
// sorted ascending, their totals, and the sign of the reordering, which is
// +1, -1, or 0 when an index repeats within either merged list.
// From acceptance to m_tvalid, the input register loads at the accepting edge,
// two stages of the odd-even transposition sort (four compare layers each)
// follow, and an output register checks repeats and packs the result.
// The pipeline takes one word per clock while m_tready stays high; every
// stage has its own valid bit and the ready chain lets a stage refill as
// soon as its word moves on.
// When the receiver holds m_tready low, words pile up stage by stage and
// s_tready falls only once all four stages are full; nothing is dropped or
// repeated. A synchronous low aresetn empties the pipeline; words in flight
// are discarded.
`default_nettype none

module fermion_product_normal_order_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Fields from bit 0: left_creators[31:0], left_creator_count[34:32],
    // left_annihilators[66:35], left_annihilator_count[69:67],
    // right_creators[101:70], right_creator_count[104:102],
    // right_annihilators[136:105], right_annihilator_count[139:137], zeros.
    input  wire logic [fpno_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // Fields from bit 0: sorted_creators[63:0], creator_total[67:64],
    // sorted_annihilators[131:68], annihilator_total[135:132],
    // phase[137:136], zeros.
    output logic [fpno_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready
);

    fpno_pkg::op_t     op;
    fpno_pkg::result_t result;

    // Stage k hands its word to stage k+1 through these.
    fpno_pkg::work_t stage_work  [fpno_pkg::SORT_STAGES:0];
    logic            stage_valid [fpno_pkg::SORT_STAGES:0];
    logic            stage_ready [fpno_pkg::SORT_STAGES:0];

    assign op = fpno_pkg::op_t'(s_tdata[fpno_pkg::IN_FIELDS_W-1:0]);

    fpno_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_work  (stage_work[0])
    );

    for (genvar g = 0; g < fpno_pkg::SORT_STAGES; g++) begin : g_sort
        fpno_sort_stage u_sort (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_work   (stage_work[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_work  (stage_work[g+1])
        );
    end

    fpno_finish u_finish (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (stage_valid[fpno_pkg::SORT_STAGES]),
        .in_ready   (stage_ready[fpno_pkg::SORT_STAGES]),
        .in_work    (stage_work[fpno_pkg::SORT_STAGES]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Zero fill above the packed result fields.
    assign m_tdata = {{(fpno_pkg::OUT_TDATA_W - fpno_pkg::OUT_FIELDS_W){1'b0}}, result};

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench of the fermion operator normal-ordering pipeline.
`default_nettype none

module testbench;
    import fpno_pkg::*;

    // Cycles without any handshake on either side before the run is abandoned.
    // The longest correct pause is the long receiver hold-off plus the
    // pipeline's own delay, so this leaves a wide margin.
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 8;

    typedef logic [INDEX_BITS-1:0] slot_list_t [MERGED_MAX];

    // Holds the expected products of accepted operator pairs and checks
    // each result word against the oldest one.
    class product_scoreboard;
        result_t expected_products[$];
        int errors;

        function int saturate(logic [IN_CNT_W-1:0] c);
            return (c > MAX_PER_LIST) ? MAX_PER_LIST : int'(c);
        endfunction

        function int append_slots(inout slot_list_t v, input int pos,
                                  input logic [LIST_W-1:0] w, input int n);
            for (int k = 0; k < n; k++) begin
                v[pos] = w[k*INDEX_BITS +: INDEX_BITS];
                pos++;
            end
            return pos;
        endfunction

        // Sorts ascending and returns the permutation sign, or zero on a repeat.
        function int sort_with_sign(inout slot_list_t v, input int n);
            int inversions;
            logic [INDEX_BITS-1:0] held;
            int j;
            inversions = 0;
            for (int a = 0; a < n; a++)
                for (int b = a + 1; b < n; b++)
                    if (v[a] > v[b]) inversions++;
            for (int a = 1; a < n; a++) begin
                held = v[a];
                j = a;
                while (j > 0 && v[j-1] > held) begin
                    v[j] = v[j-1];
                    j--;
                end
                v[j] = held;
            end
            for (int a = 1; a < n; a++)
                if (v[a] == v[a-1]) return 0;
            return inversions[0] ? -1 : 1;
        endfunction

        function logic [PACK_W-1:0] pack_slots(slot_list_t v, int n);
            logic [PACK_W-1:0] w;
            w = '0;
            for (int k = 0; k < n; k++) w[k*INDEX_BITS +: INDEX_BITS] = v[k];
            return w;
        endfunction

        function result_t normal_order_product(op_t op);
            slot_list_t cre;
            slot_list_t ann;
            int n_lc, n_la, n_rc, n_ra, nc, na, sign;
            result_t r;
            n_lc = saturate(op.left_creator_count);
            n_la = saturate(op.left_annihilator_count);
            n_rc = saturate(op.right_creator_count);
            n_ra = saturate(op.right_annihilator_count);
            for (int k = 0; k < MERGED_MAX; k++) begin
                cre[k] = '0;
                ann[k] = '0;
            end
            nc = append_slots(cre, 0, op.left_creators, n_lc);
            nc = append_slots(cre, nc, op.right_creators, n_rc);
            na = append_slots(ann, 0, op.left_annihilators, n_la);
            na = append_slots(ann, na, op.right_annihilators, n_ra);
            sign = sort_with_sign(cre, nc) * sort_with_sign(ann, na);
            // Moving the right creators past the left annihilators.
            if (((n_la * n_rc) % 2) == 1) sign = -sign;
            r.sorted_creators = pack_slots(cre, nc);
            r.creator_total = TOTAL_W'(nc);
            r.sorted_annihilators = pack_slots(ann, na);
            r.annihilator_total = TOTAL_W'(na);
            r.phase = (sign > 0) ? PHASE_PLUS : ((sign < 0) ? PHASE_MINUS : PHASE_ZERO);
            return r;
        endfunction

        function void note_op(op_t op);
            expected_products = {expected_products, normal_order_product(op)};
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(result_t got);
            result_t want;
            if (expected_products.size() == 0) begin
                report("result word arrived with no product pending");
                return;
            end
            want = expected_products.pop_front();
            if (got.sorted_creators !== want.sorted_creators)
                report($sformatf("sorted_creators got %h expected %h",
                                 got.sorted_creators, want.sorted_creators));
            if (got.creator_total !== want.creator_total)
                report($sformatf("creator_total got %0d expected %0d",
                                 got.creator_total, want.creator_total));
            if (got.sorted_annihilators !== want.sorted_annihilators)
                report($sformatf("sorted_annihilators got %h expected %h",
                                 got.sorted_annihilators, want.sorted_annihilators));
            if (got.annihilator_total !== want.annihilator_total)
                report($sformatf("annihilator_total got %0d expected %0d",
                                 got.annihilator_total, want.annihilator_total));
            if (got.phase !== want.phase)
                report($sformatf("phase got %b expected %b", got.phase, want.phase));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;

    // Control shared between the stimulus and the receiver process.
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int idle_cycles = 0;

    product_scoreboard board;

    fermion_product_normal_order_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Both channels are sampled here, at the edge, before any of this step's
    // updates land, so every word is seen exactly as the block saw it.
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) board.note_op(s_tdata[$bits(op_t)-1:0]);
        if (m_tvalid && m_tready) board.check_word(m_tdata[$bits(result_t)-1:0]);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("fermion_product_normal_order_top test failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, and no
    // stalls once the run reaches its quiet tail.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    function automatic op_t operator_pair(
        logic [LIST_W-1:0] lc, logic [IN_CNT_W-1:0] n_lc,
        logic [LIST_W-1:0] la, logic [IN_CNT_W-1:0] n_la,
        logic [LIST_W-1:0] rc, logic [IN_CNT_W-1:0] n_rc,
        logic [LIST_W-1:0] ra, logic [IN_CNT_W-1:0] n_ra);
        op_t op;
        op.left_creators = lc;
        op.left_creator_count = n_lc;
        op.left_annihilators = la;
        op.left_annihilator_count = n_la;
        op.right_creators = rc;
        op.right_creator_count = n_rc;
        op.right_annihilators = ra;
        op.right_annihilator_count = n_ra;
        return op;
    endfunction

    // Mostly counts in range, sometimes above it to exercise saturation.
    function automatic logic [IN_CNT_W-1:0] random_count();
        if ($urandom_range(0, 9) == 0) return IN_CNT_W'($urandom_range(5, 7));
        return IN_CNT_W'($urandom_range(0, 4));
    endfunction

    // Wide indices rarely collide, so most pairs give a nonzero sign; a narrow
    // range makes repeats common; a raw word covers every bit of the list.
    function automatic logic [LIST_W-1:0] random_list(int style);
        logic [LIST_W-1:0] w;
        w = LIST_W'($urandom);
        if (style == 0)
            for (int k = 0; k < MAX_PER_LIST; k++)
                w[k*INDEX_BITS +: INDEX_BITS] = INDEX_BITS'($urandom_range(0, 255));
        else if (style == 1)
            for (int k = 0; k < MAX_PER_LIST; k++)
                w[k*INDEX_BITS +: INDEX_BITS] = INDEX_BITS'($urandom_range(0, 11));
        return w;
    endfunction

    function automatic op_t random_pair();
        int pick, style;
        pick = $urandom_range(0, 9);
        style = (pick < 7) ? 0 : ((pick < 9) ? 1 : 2);
        return operator_pair(random_list(style), random_count(),
                             random_list(style), random_count(),
                             random_list(style), random_count(),
                             random_list(style), random_count());
    endfunction

    // Offers one word and waits for its handshake. A gap, when taken, lowers
    // tvalid in the acceptance step; otherwise the next word follows at once.
    task automatic send_pair(op_t op);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[$bits(op_t)-1:0] = op;
        s_tdata <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) send_pair(random_pair());
    endtask

    initial begin
        board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Everything empty, then empty with junk in unused slots.
        send_pair(operator_pair('0, 0, '0, 0, '0, 0, '0, 0));
        send_pair(operator_pair('1, 0, '1, 0, '1, 0, '1, 0));
        // Single creators at both index extremes, out of order.
        send_pair(operator_pair(32'hFFFF_FFFF, 1, '0, 0, 32'h0000_0000, 1, '0, 0));
        send_pair(operator_pair(32'h0000_0005, 1, '1, 0, '1, 0, '1, 0));
        // Right creator passes a single left annihilator: sign flips.
        send_pair(operator_pair('0, 0, 32'h0000_0001, 1, 32'h0000_0002, 1, '0, 0));
        // Even product of left annihilators and right creators (no flip), then an odd one.
        send_pair(operator_pair('0, 0, 32'h0000_0201, 2, 32'h0000_0003, 1, '0, 0));
        send_pair(operator_pair('0, 0, 32'h0003_0201, 3, 32'h0006_0504, 3, '0, 0));
        // Repeated index in the creators, then in the annihilators.
        send_pair(operator_pair(32'h0000_0003, 1, '0, 0, 32'h0000_0003, 1, '0, 0));
        send_pair(operator_pair('0, 0, 32'h0000_FF00, 2, '0, 0, 32'h0000_00FF, 1));
        // Full descending lists on both sides.
        send_pair(operator_pair(32'h0102_0304, 4, 32'h1112_1314, 4,
                                32'h0506_0708, 4, 32'h1516_1718, 4));
        // Full ascending lists, all distinct.
        send_pair(operator_pair(32'h0403_0201, 4, 32'hF4F3_F2F1, 4,
                                32'h0807_0605, 4, 32'hF8F7_F6F5, 4));
        // Counts above range saturate, with the extra slots unused anyway.
        send_pair(operator_pair(32'h0403_0201, 5, 32'h2423_2221, 6,
                                32'h0807_0605, 7, 32'h2827_2625, 7));
        send_pair(operator_pair(32'h0A0B_0C0D, 7, 32'h0000_0001, 5,
                                32'h1011_1213, 1, 32'h3000_0000, 6));
        // All ones and all zeros: every index repeats.
        send_pair(operator_pair('1, 7, '1, 7, '1, 7, '1, 7));
        send_pair(operator_pair('0, 4, '0, 4, '0, 4, '0, 4));
        // Alternating bit patterns.
        send_pair(operator_pair(32'hAA55_AA55, 4, 32'h55AA_55AA, 4,
                                32'h00AA_0055, 2, 32'h5500_AA00, 2));
        send_pair(operator_pair(32'h0000_00AA, 1, 32'h0000_0055, 1,
                                32'h0000_0055, 1, 32'h0000_00AA, 1));
        // Annihilators only, unordered, with the highest index.
        send_pair(operator_pair('1, 0, 32'h00FF_7F80, 3, '1, 0, 32'h0000_0001, 1));
        // Odd product three by three.
        send_pair(operator_pair(32'h0000_0910, 2, 32'h0030_2010, 3,
                                32'h0007_0301, 3, 32'h0000_0040, 1));

        send_random(150);

        // Long receiver hold-off while words keep coming: the pipeline fills
        // and s_tready must drop without losing or repeating anything.
        hold_request = 1'b1;
        send_random(20);

        // Let every pending result leave before offering more.
        s_tvalid <= 1'b0;
        while (board.expected_products.size() != 0) @(posedge aclk);

        send_random(150);

        // Tail of the run streams back to back with no stalls on either side.
        quiet = 1'b1;
        send_random(80);
        s_tvalid <= 1'b0;

        while (board.expected_products.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0)
            $display("fermion_product_normal_order_top test passed");
        else
            $display("fermion_product_normal_order_top test failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/fpno_pkg.sv
rtl/fpno_unpack.sv
rtl/fpno_sort_stage.sv
rtl/fpno_finish.sv
rtl/fermion_product_normal_order_top.sv
tb/sv/testbench.sv
